// ----- src/cdiv_pkg.sv -----
// Package for the complex divider: widths, status codes and the beat types
// that travel along the ratio and quotient cell chains. No dependencies.
package cdiv_pkg;

  // Operand format: signed Q16.16.
  localparam int DATA_W     = 32;
  localparam int FRAC_BITS  = 16;
  // The ratio of the smaller to the larger denominator part carries 30 fraction bits.
  localparam int RATIO_FRAC = 30;
  localparam int RATIO_W    = RATIO_FRAC + 1;
  // Products and sums of the scaled terms.
  localparam int WIDE_W     = 2 * DATA_W;
  localparam int MAG_W      = WIDE_W - 1;
  // Quotient bits produced by the long division, and the bits held in the dividend window.
  localparam int QUOT_W     = MAG_W + FRAC_BITS - RATIO_FRAC;
  localparam int HEAD_W     = QUOT_W - FRAC_BITS;
  // Pipeline length: input stage, ratio cells, multiply, add, magnitude, quotient cells, output.
  localparam int LATENCY    = 1 + RATIO_FRAC + 3 + QUOT_W + 1;

  // Status codes.
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_ZERO = 2'd1;
  localparam logic [1:0] STAT_SAT  = 2'd2;

  // One beat in the ratio division chain.
  typedef struct packed {
    logic              valid;
    logic              zero;
    logic              swap;
    logic              neg_r;
    logic [DATA_W-1:0] nr;
    logic [DATA_W-1:0] ni;
    logic [DATA_W-1:0] pivot;
    logic [DATA_W-1:0] other;
    logic [DATA_W-1:0] big;
    logic [DATA_W-1:0] rem;
    logic [RATIO_W-1:0] q;
  } ratio_beat_t;

  // One beat after the products are formed.
  typedef struct packed {
    logic              valid;
    logic              zero;
    logic              swap;
    logic [DATA_W-1:0] nr;
    logic [DATA_W-1:0] ni;
    logic [DATA_W-1:0] pivot;
    logic [WIDE_W-1:0] p_den;
    logic [WIDE_W-1:0] p_ni;
    logic [WIDE_W-1:0] p_nr;
  } mul_beat_t;

  // One beat after the scaled denominator and numerator terms are summed.
  typedef struct packed {
    logic              valid;
    logic              zero;
    logic [WIDE_W-1:0] den;
    logic [WIDE_W-1:0] tr;
    logic [WIDE_W-1:0] ti;
  } sum_beat_t;

  // One beat in the quotient division chain, both parts side by side.
  typedef struct packed {
    logic              valid;
    logic              zero;
    logic              neg_re;
    logic              neg_im;
    logic [MAG_W-1:0]  d;
    logic [MAG_W-1:0]  rem_re;
    logic [MAG_W-1:0]  rem_im;
    logic [QUOT_W-1:0] dvd_re;
    logic [QUOT_W-1:0] dvd_im;
    logic [QUOT_W-1:0] q_re;
    logic [QUOT_W-1:0] q_im;
  } quot_beat_t;

endpackage

// ----- src/cdiv_ratio_cell.sv -----
// One cell of the ratio divider: produces one quotient bit of small / big.
// Depends on cdiv_pkg.
module cdiv_ratio_cell
  import cdiv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  ratio_beat_t beat_i,
  output ratio_beat_t beat_o
);

  logic [DATA_W:0] sh;
  logic            ge;
  ratio_beat_t     beat_nxt;
  ratio_beat_t     beat_r;

  // Shift the partial remainder and try a subtraction of the divisor.
  always_comb begin
    sh       = {beat_i.rem, 1'b0};
    ge       = sh >= {1'b0, beat_i.big};
    beat_nxt = beat_i;
    if (ge) begin
      beat_nxt.rem = DATA_W'(sh - {1'b0, beat_i.big});
    end else begin
      beat_nxt.rem = sh[DATA_W-1:0];
    end
    beat_nxt.q = {beat_i.q[RATIO_W-2:0], ge};
  end

  // Cell register; only the valid bit is reset.
  always_ff @(posedge clk) begin
    beat_r <= beat_nxt;
    if (!rst_n) begin
      beat_r.valid <= 1'b0;
    end
  end

  assign beat_o = beat_r;

  // The remainder stays below the divisor for every live beat.
  a_rem_below_big: assert property (@(posedge clk) disable iff (!rst_n)
    (beat_r.valid && !beat_r.zero) |-> (beat_r.rem < beat_r.big))
    else $error("ratio remainder not below divisor");

endmodule

// ----- src/cdiv_quot_cell.sv -----
// One cell of the quotient divider: produces one bit of each quotient part.
// Depends on cdiv_pkg.
module cdiv_quot_cell
  import cdiv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  quot_beat_t beat_i,
  output quot_beat_t beat_o
);

  logic [MAG_W:0] sh_re;
  logic [MAG_W:0] sh_im;
  logic           ge_re;
  logic           ge_im;
  quot_beat_t     beat_nxt;
  quot_beat_t     beat_r;

  // Bring in the next dividend bit and try a subtraction, for both parts.
  always_comb begin
    sh_re    = {beat_i.rem_re, beat_i.dvd_re[QUOT_W-1]};
    sh_im    = {beat_i.rem_im, beat_i.dvd_im[QUOT_W-1]};
    ge_re    = sh_re >= {1'b0, beat_i.d};
    ge_im    = sh_im >= {1'b0, beat_i.d};
    beat_nxt = beat_i;
    beat_nxt.rem_re = ge_re ? MAG_W'(sh_re - {1'b0, beat_i.d}) : sh_re[MAG_W-1:0];
    beat_nxt.rem_im = ge_im ? MAG_W'(sh_im - {1'b0, beat_i.d}) : sh_im[MAG_W-1:0];
    beat_nxt.dvd_re = {beat_i.dvd_re[QUOT_W-2:0], 1'b0};
    beat_nxt.dvd_im = {beat_i.dvd_im[QUOT_W-2:0], 1'b0};
    beat_nxt.q_re   = {beat_i.q_re[QUOT_W-2:0], ge_re};
    beat_nxt.q_im   = {beat_i.q_im[QUOT_W-2:0], ge_im};
  end

  // Cell register; only the valid bit is reset.
  always_ff @(posedge clk) begin
    beat_r <= beat_nxt;
    if (!rst_n) begin
      beat_r.valid <= 1'b0;
    end
  end

  assign beat_o = beat_r;

  // Both remainders stay below the divisor for every live beat.
  a_rem_below_d: assert property (@(posedge clk) disable iff (!rst_n)
    (beat_r.valid && !beat_r.zero) |-> (beat_r.rem_re < beat_r.d && beat_r.rem_im < beat_r.d))
    else $error("quotient remainder not below divisor");

endmodule

// ----- src/complex_divider.sv -----
// Complex divider by Smith's method, signed Q16.16 in and out.
// The pipeline runs from the start beat to the out_valid strobe through one input stage,
// 30 ratio cells, multiply, add and magnitude stages, 49 quotient cells, one output stage.
// Throughput is one beat per cycle; busy is low whenever reset is released.
// Reset is synchronous and clears only the valid bits of the pipeline.
// Depends on cdiv_pkg, cdiv_ratio_cell and cdiv_quot_cell.
module complex_divider
  import cdiv_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [DATA_W-1:0] in_num_real,
  input  logic [DATA_W-1:0] in_num_imag,
  input  logic [DATA_W-1:0] in_den_real,
  input  logic [DATA_W-1:0] in_den_imag,
  output logic              out_valid,
  output logic [DATA_W-1:0] out_quot_real,
  output logic [DATA_W-1:0] out_quot_imag,
  output logic [1:0]        out_status
);

  localparam logic [DATA_W-1:0] HALF = {1'b1, {(DATA_W-1){1'b0}}};

  logic [DATA_W-1:0] mag_dr;
  logic [DATA_W-1:0] mag_di;
  logic [DATA_W-1:0] mag_small;
  logic              first_bit;
  ratio_beat_t       in_nxt;
  ratio_beat_t       rb [RATIO_FRAC+1];
  ratio_beat_t       rt;
  logic [DATA_W-1:0] r_val;
  mul_beat_t         mul_nxt;
  mul_beat_t         mul_r;
  logic [WIDE_W-1:0] pivot_w;
  logic [WIDE_W-1:0] nr_w;
  logic [WIDE_W-1:0] ni_w;
  sum_beat_t         sum_nxt;
  sum_beat_t         sum_r;
  logic [WIDE_W-1:0] den_m;
  logic [WIDE_W-1:0] tr_m;
  logic [WIDE_W-1:0] ti_m;
  quot_beat_t        qb [QUOT_W+1];
  quot_beat_t        qt;
  logic [DATA_W:0]   fin_re;
  logic [DATA_W:0]   fin_im;
  logic              out_valid_nxt;
  logic [DATA_W-1:0] quot_real_nxt;
  logic [DATA_W-1:0] quot_imag_nxt;
  logic [1:0]        status_nxt;
  logic              out_valid_r;
  logic [DATA_W-1:0] quot_real_r;
  logic [DATA_W-1:0] quot_imag_r;
  logic [1:0]        status_r;

  // Saturate and apply the sign to one quotient part; bit DATA_W flags saturation.
  function automatic logic [DATA_W:0] finish(input logic [QUOT_W-1:0] q, input logic neg);
    logic [DATA_W-1:0] lim;
    logic              sat;
    logic [DATA_W-1:0] v;
    lim = neg ? HALF : HALF - 1'b1;
    sat = (|q[QUOT_W-1:DATA_W]) || (q[DATA_W-1:0] > lim);
    v   = sat ? lim : q[DATA_W-1:0];
    return {sat, neg ? DATA_W'(-v) : v};
  endfunction

  assign busy = !rst_n;

  // Input stage: pick the pivot and produce the leading ratio bit.
  always_comb begin
    mag_dr = in_den_real[DATA_W-1] ? DATA_W'(-in_den_real) : in_den_real;
    mag_di = in_den_imag[DATA_W-1] ? DATA_W'(-in_den_imag) : in_den_imag;
    in_nxt.valid = start && !busy;
    in_nxt.zero  = (in_den_real == '0) && (in_den_imag == '0);
    in_nxt.swap  = mag_di > mag_dr;
    in_nxt.neg_r = in_den_real[DATA_W-1] ^ in_den_imag[DATA_W-1];
    in_nxt.nr    = in_num_real;
    in_nxt.ni    = in_num_imag;
    in_nxt.pivot = in_nxt.swap ? in_den_imag : in_den_real;
    in_nxt.other = in_nxt.swap ? in_den_real : in_den_imag;
    in_nxt.big   = in_nxt.swap ? mag_di : mag_dr;
    mag_small    = in_nxt.swap ? mag_dr : mag_di;
    first_bit    = mag_small >= in_nxt.big;
    in_nxt.rem   = first_bit ? DATA_W'(mag_small - in_nxt.big) : mag_small;
    in_nxt.q     = RATIO_W'(first_bit);
  end

  always_ff @(posedge clk) begin
    rb[0] <= in_nxt;
    if (!rst_n) begin
      rb[0].valid <= 1'b0;
    end
  end

  // Ratio division chain, one bit per cell.
  for (genvar k = 0; k < RATIO_FRAC; k++) begin : g_ratio
    cdiv_ratio_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .beat_i (rb[k]),
      .beat_o (rb[k+1])
    );
  end

  // Multiply stage: the signed ratio times the other denominator part and both numerator parts.
  always_comb begin
    rt            = rb[RATIO_FRAC];
    r_val         = rt.neg_r ? DATA_W'(-{1'b0, rt.q}) : DATA_W'({1'b0, rt.q});
    mul_nxt.valid = rt.valid;
    mul_nxt.zero  = rt.zero;
    mul_nxt.swap  = rt.swap;
    mul_nxt.nr    = rt.nr;
    mul_nxt.ni    = rt.ni;
    mul_nxt.pivot = rt.pivot;
    mul_nxt.p_den = WIDE_W'($signed(r_val) * $signed(rt.other));
    mul_nxt.p_ni  = WIDE_W'($signed(r_val) * $signed(rt.ni));
    mul_nxt.p_nr  = WIDE_W'($signed(r_val) * $signed(rt.nr));
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_nxt;
    if (!rst_n) begin
      mul_r.valid <= 1'b0;
    end
  end

  // Add stage: scaled denominator and the two numerator terms of the chosen branch.
  always_comb begin
    pivot_w       = WIDE_W'($signed(mul_r.pivot)) << RATIO_FRAC;
    nr_w          = WIDE_W'($signed(mul_r.nr)) << RATIO_FRAC;
    ni_w          = WIDE_W'($signed(mul_r.ni)) << RATIO_FRAC;
    sum_nxt.valid = mul_r.valid;
    sum_nxt.zero  = mul_r.zero;
    sum_nxt.den   = pivot_w + mul_r.p_den;
    if (mul_r.swap) begin
      sum_nxt.tr = mul_r.p_nr + ni_w;
      sum_nxt.ti = mul_r.p_ni - nr_w;
    end else begin
      sum_nxt.tr = nr_w + mul_r.p_ni;
      sum_nxt.ti = ni_w - mul_r.p_nr;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    if (!rst_n) begin
      sum_r.valid <= 1'b0;
    end
  end

  // Magnitude stage: split signs off and load the long division window.
  always_comb begin
    den_m = sum_r.den[WIDE_W-1] ? -sum_r.den : sum_r.den;
    tr_m  = sum_r.tr[WIDE_W-1] ? -sum_r.tr : sum_r.tr;
    ti_m  = sum_r.ti[WIDE_W-1] ? -sum_r.ti : sum_r.ti;
  end

  always_ff @(posedge clk) begin
    qb[0].valid  <= sum_r.valid;
    qb[0].zero   <= sum_r.zero;
    qb[0].neg_re <= sum_r.tr[WIDE_W-1] ^ sum_r.den[WIDE_W-1];
    qb[0].neg_im <= sum_r.ti[WIDE_W-1] ^ sum_r.den[WIDE_W-1];
    qb[0].d      <= den_m[MAG_W-1:0];
    qb[0].rem_re <= MAG_W'(tr_m[MAG_W-1:HEAD_W]);
    qb[0].rem_im <= MAG_W'(ti_m[MAG_W-1:HEAD_W]);
    qb[0].dvd_re <= {tr_m[HEAD_W-1:0], {FRAC_BITS{1'b0}}};
    qb[0].dvd_im <= {ti_m[HEAD_W-1:0], {FRAC_BITS{1'b0}}};
    qb[0].q_re   <= '0;
    qb[0].q_im   <= '0;
    if (!rst_n) begin
      qb[0].valid <= 1'b0;
    end
  end

  // Quotient division chain, one bit of each part per cell.
  for (genvar k = 0; k < QUOT_W; k++) begin : g_quot
    cdiv_quot_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .beat_i (qb[k]),
      .beat_o (qb[k+1])
    );
  end

  // Output stage: saturation, sign and status.
  always_comb begin
    qt            = qb[QUOT_W];
    fin_re        = finish(qt.q_re, qt.neg_re);
    fin_im        = finish(qt.q_im, qt.neg_im);
    out_valid_nxt = qt.valid;
    if (qt.zero) begin
      quot_real_nxt = '0;
      quot_imag_nxt = '0;
      status_nxt    = STAT_ZERO;
    end else begin
      quot_real_nxt = fin_re[DATA_W-1:0];
      quot_imag_nxt = fin_im[DATA_W-1:0];
      status_nxt    = (fin_re[DATA_W] || fin_im[DATA_W]) ? STAT_SAT : STAT_OK;
    end
  end

  always_ff @(posedge clk) begin
    quot_real_r <= quot_real_nxt;
    quot_imag_r <= quot_imag_nxt;
    status_r    <= status_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_quot_real = quot_real_r;
  assign out_quot_imag = quot_imag_r;
  assign out_status    = status_r;

  // A zero denominator always yields a zero quotient.
  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STAT_ZERO) |-> (out_quot_real == '0 && out_quot_imag == '0))
    else $error("zero denominator gave a nonzero quotient");

  // A saturated beat has at least one part clamped to a range limit.
  a_sat_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STAT_SAT) |->
      (out_quot_real == HALF || out_quot_real == HALF - 1'b1 ||
       out_quot_imag == HALF || out_quot_imag == HALF - 1'b1))
    else $error("saturation reported without a clamped part");

  // A beat that enters the quotient chain leaves the block after the fixed delay.
  a_chain_delay: assert property (@(posedge clk) disable iff (!rst_n)
    qb[0].valid |-> ##(QUOT_W+1) out_valid)
    else $error("quotient chain lost a beat");

endmodule

// ----- tb/complex_divider_tb.sv -----
// Testbench for the complex divider: a directed table, then random bursts, each result
// checked against a typed-in expectation or a behavioural Smith-division predictor.
// Depends on cdiv_pkg and complex_divider.
module complex_divider_tb
  import cdiv_pkg::*;
();

  typedef struct packed {
    logic [31:0] nr;
    logic [31:0] ni;
    logic [31:0] dr;
    logic [31:0] di;
  } operands_t;

  typedef struct packed {
    logic [31:0] qr;
    logic [31:0] qi;
    logic [1:0]  st;
  } quotient_t;

  // One row of the directed table; the expected value is used only when typed in.
  typedef struct packed {
    operands_t ops;
    logic      typed;
    quotient_t exp_q;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_num_real, in_num_imag, in_den_real, in_den_imag;
  logic        out_valid;
  logic [31:0] out_quot_real, out_quot_imag;
  logic [1:0]  out_status;

  quotient_t   pending_q[$];
  int          errors;
  int          beats_sent;
  int          beats_checked;
  int          sat_seen;
  int          zero_seen;

  complex_divider uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_num_real(in_num_real), .in_num_imag(in_num_imag),
    .in_den_real(in_den_real), .in_den_imag(in_den_imag),
    .out_valid(out_valid), .out_quot_real(out_quot_real),
    .out_quot_imag(out_quot_imag), .out_status(out_status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Absolute value of a signed 64-bit term, as an unsigned value.
  function automatic logic [63:0] abs64(input logic signed [63:0] x);
    abs64 = x[63] ? 64'd0 - x : x;
  endfunction

  // One quotient part: floor(|t| * 2^16 / |d|) by long division, signed and clamped.
  function automatic logic [31:0] quot_part(input logic signed [63:0] t,
                                            input logic signed [63:0] d,
                                            inout logic sat);
    logic        neg;
    logic [63:0] lim, q, rem, dm;
    neg = t[63] != d[63];
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    dm  = abs64(d);
    q   = abs64(t) / dm;
    rem = abs64(t) % dm;
    for (int k = 0; k < FRAC_BITS; k++) begin
      if (q > lim) break;
      rem = rem << 1;
      q   = q << 1;
      if (rem >= dm) begin
        rem = rem - dm;
        q[0] = 1'b1;
      end
    end
    if (q > lim) begin
      sat = 1'b1;
      q = lim;
    end
    quot_part = neg ? 32'(64'd0 - q) : q[31:0];
  endfunction

  // Smith's division of one complex pair.
  function automatic quotient_t smith_divide(input operands_t o);
    logic signed [63:0] nr, ni, dr, di, r, den, tr, ti;
    logic [63:0]        mr;
    logic               sat;
    quotient_t          res;
    nr = $signed(o.nr); ni = $signed(o.ni);
    dr = $signed(o.dr); di = $signed(o.di);
    sat = 1'b0;
    if (dr == 0 && di == 0) begin
      res.qr = '0; res.qi = '0; res.st = STAT_ZERO;
      return res;
    end
    if (abs64(dr) >= abs64(di)) begin
      mr  = (abs64(di) << RATIO_FRAC) / abs64(dr);
      r   = (di[63] != dr[63]) ? -$signed(mr) : $signed(mr);
      den = (dr <<< RATIO_FRAC) + r * di;
      tr  = (nr <<< RATIO_FRAC) + r * ni;
      ti  = (ni <<< RATIO_FRAC) - r * nr;
    end else begin
      mr  = (abs64(dr) << RATIO_FRAC) / abs64(di);
      r   = (di[63] != dr[63]) ? -$signed(mr) : $signed(mr);
      den = (di <<< RATIO_FRAC) + r * dr;
      tr  = r * nr + (ni <<< RATIO_FRAC);
      ti  = r * ni - (nr <<< RATIO_FRAC);
    end
    res.qr = quot_part(tr, den, sat);
    res.qi = quot_part(ti, den, sat);
    res.st = sat ? STAT_SAT : STAT_OK;
    return res;
  endfunction

  // Random operand word, biased towards extremes and small magnitudes.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: pick_word = 32'h8000_0000;
      1: pick_word = 32'h7FFF_FFFF;
      2: pick_word = 32'($signed($urandom_range(0, 131072)) - 65536);
      3: pick_word = '0;
      default: pick_word = $urandom;
    endcase
  endfunction

  // Drive one beat; the caller is on a rising edge and start is held until accepted.
  task automatic send_beat(input operands_t o, input quotient_t q);
    in_num_real <= o.nr; in_num_imag <= o.ni;
    in_den_real <= o.dr; in_den_imag <= o.di;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_q.push_back(q);
    beats_sent++;
  endtask

  // Result checker: every strobe is compared with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h %h %0d", $time,
                 out_quot_real, out_quot_imag, out_status);
        errors++;
      end else begin
        quotient_t e;
        e = pending_q.pop_front();
        if (e.qr !== out_quot_real || e.qi !== out_quot_imag || e.st !== out_status) begin
          $display("%0t: mismatch expected %h %h %0d actual %h %h %0d", $time,
                   e.qr, e.qi, e.st, out_quot_real, out_quot_imag, out_status);
          errors++;
        end
        if (out_status == STAT_SAT) sat_seen++;
        if (out_status == STAT_ZERO) zero_seen++;
        beats_checked++;
      end
    end
  end

  // Directed table: extremes, both pivot branches, equal magnitudes, zero, overflow.
  localparam int N_DIR = 16;
  localparam quotient_t Q_ZERO = '{qr: 32'd0, qi: 32'd0, st: STAT_ZERO};
  stim_row_t dir_tab [N_DIR] = '{
    '{ops: '{32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0}, typed: 1'b1, exp_q: Q_ZERO},
    '{ops: '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0}, typed: 1'b1, exp_q: Q_ZERO},
    '{ops: '{32'h0003_0000, 32'hFFFE_0000, 32'h0001_0000, 32'h0}, typed: 1'b1,
      exp_q: '{qr: 32'h0003_0000, qi: 32'hFFFE_0000, st: STAT_OK}},
    '{ops: '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0}, typed: 1'b1,
      exp_q: '{qr: 32'h7FFF_FFFF, qi: 32'h8000_0000, st: STAT_SAT}},
    '{ops: '{32'h0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF}, typed: 1'b1,
      exp_q: '{qr: 32'h0, qi: 32'h0, st: STAT_OK}},
    '{ops: '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000}, typed: 1'b0,
      exp_q: '0},
    '{ops: '{32'h0001_0000, 32'h0, 32'h0001_0000, 32'hFFFF_0000}, typed: 1'b0, exp_q: '0},
    '{ops: '{32'h0002_0000, 32'h0005_0000, 32'h0, 32'h0001_0000}, typed: 1'b0, exp_q: '0},
    '{ops: '{32'h0002_0000, 32'h0005_0000, 32'h0000_4000, 32'hFFFD_0000}, typed: 1'b0,
      exp_q: '0},
    '{ops: '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, typed: 1'b0,
      exp_q: '0},
    '{ops: '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000}, typed: 1'b0,
      exp_q: '0},
    '{ops: '{32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF, 32'h0000_0001}, typed: 1'b0,
      exp_q: '0},
    '{ops: '{32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h0}, typed: 1'b0, exp_q: '0},
    '{ops: '{32'h1234_5678, 32'h9ABC_DEF0, 32'h0, 32'h8000_0000}, typed: 1'b0, exp_q: '0},
    '{ops: '{32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0003, 32'h0000_0002}, typed: 1'b0,
      exp_q: '0},
    '{ops: '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, typed: 1'b0,
      exp_q: '0}
  };

  // Main stimulus: reset, directed table, then random bursts with gaps.
  initial begin
    operands_t ops;
    int        burst;
    errors = 0; beats_sent = 0; beats_checked = 0; sat_seen = 0; zero_seen = 0;
    rst_n = 1'b0; start = 1'b0;
    in_num_real = '0; in_num_imag = '0; in_den_real = '0; in_den_imag = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      send_beat(dir_tab[i].ops,
                dir_tab[i].typed ? dir_tab[i].exp_q : smith_divide(dir_tab[i].ops));
    end
    start <= 1'b0;

    while (beats_sent < 1250) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst; b++) begin
        ops.nr = pick_word(); ops.ni = pick_word();
        ops.dr = pick_word(); ops.di = pick_word();
        send_beat(ops, smith_divide(ops));
      end
      start <= 1'b0;
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 12)) @(posedge clk);
      else @(posedge clk);
    end
    start <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    $display("Covered %0d beats (%0d checked), %0d saturated and %0d zero-denominator.",
             beats_sent, beats_checked, sat_seen, zero_seen);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // Watchdog for a stuck pipeline.
  initial begin
    #200000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- complex_divider.f -----
src/cdiv_pkg.sv
src/cdiv_ratio_cell.sv
src/cdiv_quot_cell.sv
src/complex_divider.sv
tb/complex_divider_tb.sv
